### design/srtf_preemptive_scheduler_unit_defines.svh
// Assertion macros used by the scheduler RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_UNIT_DEFINES_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRTF_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define SRTF_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SRTF_ASSERT_IMP(label, clk, rstn, pre, post)
`define SRTF_ASSERT_NXT(label, clk, rstn, pre, post)
`endif
`endif

### design/srtf_pkg.sv
// Types and constants of the shortest-remaining-time scheduler.
// Used by the scheduler top level and its testbench.
package srtf_pkg;
    localparam logic [1:0] KIND_PREEMPT  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_REJECT   = 2'd2;
    localparam int unsigned SEG_W = 16;
    localparam logic [SEG_W-1:0] SEG_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_RD_CUR, ST_DECIDE, ST_RD_WIN,
        ST_UPDATE, ST_OUT1, ST_OUT2
    } state_t;
endpackage

### design/srtf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/srtf_preemptive_scheduler_unit.sv
// An accepted add is written to the table and the input stays ready; a rejected add shows
// its beat in the next cycle. A tick shows its first result beat after the slot scan through
// the one read port of the process table memory and the RD_CUR, DECIDE, RD_WIN, UPDATE states.
// One item is in work at a time: an idle tick frees the input after DECIDE, a tick
// without results after UPDATE, and a tick with results after its last beat is taken.
// Reset (aresetn low, synchronous) clears valid bits, time, running slot and the state.
`include "srtf_preemptive_scheduler_unit_defines.svh"
module srtf_preemptive_scheduler_unit
    import srtf_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[0], process_id[8:1], burst_time[24:9], zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[1:0], proc_tag[9:2], segment_start[25:10], segment_length[41:26],
    // response_time[57:42], waiting_time[73:58], turnaround_time[89:74], zero fill
    output logic [95:0] m_tdata,
    output logic        m_tlast
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = TIME_BITS;
    // Entry: tag, remaining, burst, arrival, first start, started, seg begin, seg run.
    localparam int EW = 8 + 16 + 16 + TW + TW + 1 + TW + 16;
    localparam logic [TW-1:0] TMAX = '1;

    typedef struct packed {
        logic [7:0]    tag;
        logic [15:0]   rem;
        logic [15:0]   burst;
        logic [TW-1:0] arrival;
        logic [TW-1:0] first;
        logic          started;
        logic [TW-1:0] sbeg;
        logic [15:0]   srun;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] resp;
        logic [15:0] waitt;
        logic [15:0] turn;
    } res_t;

    state_t state_reg, state_next;
    logic [SLOTS-1:0] valid_reg;
    logic [TW-1:0]    time_reg;
    logic [SW-1:0]    run_slot_reg;
    logic             run_valid_reg;
    logic [SW:0]      scan_reg;
    logic [SW-1:0]    best_reg;
    logic [15:0]      best_rem_reg;
    logic             found_reg;
    logic [SW-1:0]    win_reg;
    logic             pre_reg;
    entry_t           cur_reg;
    res_t             r1_reg, r2_reg;
    logic             has2_reg;
    res_t             out_sel;

    logic          we;
    logic [SW-1:0] waddr, raddr;
    entry_t        wdata, rdata_e;
    logic [EW-1:0] rdata;

    srtf_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    assign rdata_e = entry_t'(rdata);

    // Lowest free slot.
    logic [SW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    logic in_acc, out_acc, out_last;
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign out_last = (state_reg == ST_OUT2) || !has2_reg;
    logic [SW-1:0] scan_idx;
    assign scan_idx = scan_reg[SW-1:0];

    // The running process keeps the unit unless the best one has strictly less left.
    logic keep_cur;
    assign keep_cur = run_valid_reg && valid_reg[run_slot_reg]
                      && !(best_rem_reg < rdata_e.rem);

    // Tick update of the winning entry.
    entry_t upd;
    logic [15:0] new_rem;
    logic [TW-1:0] t_inc;
    logic [TW-1:0] resp_t, turn_t, sa_t, wait_t;
    always_comb begin
        upd = cur_reg;
        if (pre_reg || !run_valid_reg || !valid_reg[run_slot_reg]
                || win_reg != run_slot_reg) begin
            upd.sbeg = time_reg;
            upd.srun = '0;
        end
        if (!upd.started) begin
            upd.started = 1'b1;
            upd.first   = time_reg;
        end
        new_rem  = upd.rem - 16'd1;
        upd.rem  = new_rem;
        if (upd.srun != SEG_MAX) upd.srun = upd.srun + 16'd1;
        t_inc  = (time_reg != TMAX) ? time_reg + 1'b1 : time_reg;
        resp_t = (upd.first > upd.arrival) ? upd.first - upd.arrival : '0;
        turn_t = (t_inc > upd.first) ? t_inc - upd.first : '0;
        sa_t   = (t_inc > upd.arrival) ? t_inc - upd.arrival : '0;
        wait_t = (sa_t > TW'(upd.burst)) ? sa_t - TW'(upd.burst) : '0;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) begin
                state_next = s_tdata[0] ? ST_SCAN : ST_IDLE;
                if (!s_tdata[0] && !free_ok) state_next = ST_OUT1;
            end
            ST_SCAN: if (scan_reg == (SW+1)'(SLOTS - 1)) state_next = ST_SCAN_LAST;
            ST_SCAN_LAST: state_next = ST_RD_CUR;
            ST_RD_CUR: state_next = ST_DECIDE;
            ST_DECIDE: state_next = found_reg ? ST_RD_WIN : ST_IDLE;
            ST_RD_WIN: state_next = ST_UPDATE;
            ST_UPDATE: state_next = (pre_reg || new_rem == 16'd0) ? ST_OUT1 : ST_IDLE;
            ST_OUT1: if (out_acc) state_next = has2_reg ? ST_OUT2 : ST_IDLE;
            ST_OUT2: if (out_acc) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory port control.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
        m_tlast  = out_last;
        out_sel  = (state_reg == ST_OUT2) ? r2_reg : r1_reg;
        m_tdata  = {6'd0, out_sel.turn, out_sel.waitt, out_sel.resp, out_sel.len,
                    out_sel.start, out_sel.tag, out_sel.kind};
        raddr    = scan_idx;
        we       = 1'b0;
        waddr    = free_idx;
        wdata    = upd;
        case (state_reg)
            ST_IDLE: begin
                raddr = '0;
                wdata = '{tag: s_tdata[8:1],
                          rem: (s_tdata[24:9] == 16'd0) ? 16'd1 : s_tdata[24:9],
                          burst: (s_tdata[24:9] == 16'd0) ? 16'd1 : s_tdata[24:9],
                          arrival: time_reg, first: '0, started: 1'b0,
                          sbeg: '0, srun: '0};
                we = in_acc && !s_tdata[0] && free_ok;
            end
            ST_SCAN_LAST: raddr = run_slot_reg;
            ST_RD_CUR:    raddr = run_slot_reg;
            ST_DECIDE:    raddr = keep_cur ? run_slot_reg : best_reg;
            ST_UPDATE: begin
                we    = 1'b1;
                waddr = win_reg;
            end
            default: ;
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            time_reg      <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (in_acc) begin
                    scan_reg     <= (SW+1)'(1);
                    found_reg    <= 1'b0;
                    pre_reg      <= 1'b0;
                    has2_reg     <= 1'b0;
                    if (!s_tdata[0]) begin
                        if (free_ok) valid_reg[free_idx] <= 1'b1;
                        r1_reg <= '{kind: KIND_REJECT, tag: s_tdata[8:1], default: '0};
                    end
                end
                ST_SCAN, ST_SCAN_LAST: begin
                    // Data for slot scan-1 arrives this cycle.
                    if (valid_reg[scan_idx - 1'b1]
                            && (!found_reg || rdata_e.rem < best_rem_reg)) begin
                        best_reg     <= scan_idx - 1'b1;
                        best_rem_reg <= rdata_e.rem;
                        found_reg    <= 1'b1;
                    end
                    if (state_reg == ST_SCAN) scan_reg <= scan_reg + 1'b1;
                end
                ST_RD_CUR: ;
                ST_DECIDE: begin
                    if (!found_reg) begin
                        run_valid_reg <= 1'b0;
                        if (time_reg != TMAX) time_reg <= time_reg + 1'b1;
                    end else if (run_valid_reg && valid_reg[run_slot_reg]) begin
                        if (best_rem_reg < rdata_e.rem) begin
                            pre_reg  <= 1'b1;
                            win_reg  <= best_reg;
                            r1_reg   <= '{kind: KIND_PREEMPT, tag: rdata_e.tag,
                                          start: 16'(rdata_e.sbeg), len: rdata_e.srun,
                                          default: '0};
                        end else begin
                            win_reg <= run_slot_reg;
                        end
                    end else begin
                        win_reg <= best_reg;
                    end
                end
                ST_RD_WIN: ;
                ST_UPDATE: begin
                    time_reg      <= t_inc;
                    run_slot_reg  <= win_reg;
                    run_valid_reg <= (new_rem != 16'd0);
                    if (new_rem == 16'd0) begin
                        valid_reg[win_reg] <= 1'b0;
                        if (pre_reg) has2_reg <= 1'b1;
                    end
                    if (new_rem == 16'd0) begin
                        if (pre_reg) begin
                            r2_reg <= '{KIND_COMPLETE, upd.tag, 16'(upd.sbeg), upd.srun,
                                        16'(resp_t), 16'(wait_t), 16'(turn_t)};
                        end else begin
                            r1_reg <= '{KIND_COMPLETE, upd.tag, 16'(upd.sbeg), upd.srun,
                                        16'(resp_t), 16'(wait_t), 16'(turn_t)};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The winner entry arrives in RD_WIN; capture it for the update.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_WIN) cur_reg <= rdata_e;
    end

    `SRTF_ASSERT_IMP(a_no_in_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `SRTF_ASSERT_IMP(a_out2_last, aclk, aresetn, state_reg == ST_OUT2, m_tlast)
    `SRTF_ASSERT_NXT(a_reject_out, aclk, aresetn,
        in_acc && !s_tdata[0] && !free_ok, m_tvalid && m_tdata[1:0] == KIND_REJECT)
endmodule

### tb/sv/tb_srtf_preemptive_scheduler_unit.sv
// Self-checking bench for the preemptive shortest-remaining-time scheduler.
// Needs srtf_pkg and srtf_preemptive_scheduler_unit; drives beats and predicts results.
module tb_srtf_preemptive_scheduler_unit;
    import srtf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    // One result beat as the scheduler reports it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [15:0] seg_start;
        logic [15:0] seg_len;
        logic [15:0] resp;
        logic [15:0] wait_t;
        logic [15:0] turn;
        logic        last;
    } sched_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;

    srtf_preemptive_scheduler_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the process table.
    logic        occ [NSLOT];
    logic [7:0]  ptag [NSLOT];
    logic [15:0] left_units [NSLOT];
    logic [15:0] burst_len [NSLOT];
    logic [15:0] arrived_at [NSLOT];
    logic [15:0] started_at [NSLOT];
    logic        started [NSLOT];
    logic [15:0] seg_from [NSLOT];
    logic [15:0] seg_units [NSLOT];
    logic [15:0] now_units;
    int          run_idx;
    logic        run_ok;

    sched_result_t pending_results[$];
    int  errors;
    int  beats_seen;
    int  n_preempt, n_complete, n_reject;
    int  cycles = 0;
    bit  idle_m;
    bit  hold_off;
    bit  quiet;

    function automatic logic [15:0] sub_floor(logic [15:0] a, logic [15:0] b);
        return (a > b) ? a - b : 16'd0;
    endfunction

    function automatic sched_result_t mk_result(logic [1:0] k, logic [7:0] t,
                                                logic [15:0] s, logic [15:0] l,
                                                logic [15:0] r, logic [15:0] w,
                                                logic [15:0] u);
        sched_result_t x;
        x.kind = k; x.tag = t; x.seg_start = s; x.seg_len = l;
        x.resp = r; x.wait_t = w; x.turn = u; x.last = 1'b0;
        return x;
    endfunction

    // Advance the shadow table by one accepted beat and queue its results.
    task automatic schedule_beat(input logic act, input logic [7:0] id,
                                 input logic [15:0] bl);
        sched_result_t outs[$];
        int free_i, best, cur;
        bit found;
        free_i = -1; best = 0; found = 0;
        if (act == ACT_ADD) begin
            for (int i = NSLOT - 1; i >= 0; i--) if (!occ[i]) free_i = i;
            if (free_i < 0) begin
                outs.insert(outs.size(), mk_result(KIND_REJECT, id, 16'd0, 16'd0,
                                                   16'd0, 16'd0, 16'd0));
            end else begin
                occ[free_i] = 1'b1;
                ptag[free_i] = id;
                left_units[free_i] = (bl == 0) ? 16'd1 : bl;
                burst_len[free_i] = (bl == 0) ? 16'd1 : bl;
                arrived_at[free_i] = now_units;
                started[free_i] = 1'b0;
                started_at[free_i] = '0;
                seg_from[free_i] = '0;
                seg_units[free_i] = '0;
            end
        end else begin
            for (int i = 0; i < NSLOT; i++)
                if (occ[i] && (!found || left_units[i] < left_units[best])) begin
                    best = i;
                    found = 1;
                end
            if (!found) begin
                run_ok = 1'b0;
                if (now_units != 16'hFFFF) now_units++;
            end else begin
                if (run_ok && occ[run_idx]) begin
                    cur = run_idx;
                    if (left_units[best] < left_units[cur]) begin
                        outs.insert(outs.size(), mk_result(KIND_PREEMPT, ptag[cur],
                                    seg_from[cur], seg_units[cur], 16'd0, 16'd0, 16'd0));
                        cur = best;
                        seg_from[cur] = now_units;
                        seg_units[cur] = '0;
                    end
                end else begin
                    cur = best;
                    seg_from[cur] = now_units;
                    seg_units[cur] = '0;
                end
                run_idx = cur;
                run_ok = 1'b1;
                if (!started[cur]) begin
                    started[cur] = 1'b1;
                    started_at[cur] = now_units;
                end
                left_units[cur]--;
                if (seg_units[cur] != 16'hFFFF) seg_units[cur]++;
                if (now_units != 16'hFFFF) now_units++;
                if (left_units[cur] == 0) begin
                    outs.insert(outs.size(), mk_result(KIND_COMPLETE, ptag[cur],
                        seg_from[cur], seg_units[cur],
                        sub_floor(started_at[cur], arrived_at[cur]),
                        sub_floor(sub_floor(now_units, arrived_at[cur]), burst_len[cur]),
                        sub_floor(now_units, started_at[cur])));
                    occ[cur] = 1'b0;
                    run_ok = 1'b0;
                end
            end
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) pending_results.insert(pending_results.size(), outs[i]);
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        int hold_cnt;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                hold_cnt = 0;
                m_tready <= 1'b0;
                while (hold_cnt < 300) begin
                    @(posedge aclk);
                    hold_cnt++;
                end
                hold_off = 0;
            end
            m_tready <= (quiet || !idle_m) ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        sched_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tdata[1:0];
            got.tag = m_tdata[9:2];
            got.seg_start = m_tdata[25:10];
            got.seg_len = m_tdata[41:26];
            got.resp = m_tdata[57:42];
            got.wait_t = m_tdata[73:58];
            got.turn = m_tdata[89:74];
            got.last = m_tlast;
            beats_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d tag %0d",
                       got.kind, got.tag);
                errors++;
            end else begin
                want = pending_results.pop_front();
                case (got.kind)
                    KIND_PREEMPT:  n_preempt++;
                    KIND_COMPLETE: n_complete++;
                    default:       n_reject++;
                endcase
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
                end
                if (got.tag != want.tag) begin
                    $error("proc_tag: expected %0d, got %0d", want.tag, got.tag); errors++;
                end
                if (got.seg_start != want.seg_start) begin
                    $error("segment_start: expected %0d, got %0d",
                           want.seg_start, got.seg_start); errors++;
                end
                if (got.seg_len != want.seg_len) begin
                    $error("segment_length: expected %0d, got %0d",
                           want.seg_len, got.seg_len); errors++;
                end
                if (got.resp != want.resp) begin
                    $error("response_time: expected %0d, got %0d", want.resp, got.resp);
                    errors++;
                end
                if (got.wait_t != want.wait_t) begin
                    $error("waiting_time: expected %0d, got %0d",
                           want.wait_t, got.wait_t); errors++;
                end
                if (got.turn != want.turn) begin
                    $error("turnaround_time: expected %0d, got %0d", want.turn, got.turn);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last); errors++;
                end
                if (m_tdata[95:90] != 0) begin
                    $error("zero fill: expected 0, got %0h", m_tdata[95:90]); errors++;
                end
            end
        end
    end

    // Offer one beat and wait for its handshake, with optional random gaps.
    task automatic send_beat(input logic act, input logic [7:0] id,
                             input logic [15:0] bl);
        while (!quiet && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, bl, id, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        schedule_beat(act, id, bl);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
    endtask

    // Directed rows; every result is checked against the shadow table.
    typedef struct {
        logic        act;
        logic [7:0]  id;
        logic [15:0] bl;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{ACT_TICK, 8'd0,   16'd0},     // idle tick right after reset
        '{ACT_ADD,  8'd0,   16'd0},     // tag zero, zero burst taken as one
        '{ACT_TICK, 8'd0,   16'd0},     // completes at once
        '{ACT_ADD,  8'd255, 16'hFFFF},  // largest tag and burst
        '{ACT_ADD,  8'd1,   16'd3},
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_ADD,  8'd2,   16'd1},     // shorter job arrives while slot 1 runs
        '{ACT_TICK, 8'd0,   16'd0},     // preempt then complete on one tick
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_ADD,  8'd3,   16'd2},
        '{ACT_ADD,  8'd4,   16'd2},     // tie goes to the lower slot
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_TICK, 8'd0,   16'd0},
        '{ACT_TICK, 8'd0,   16'd0}
    };

    initial begin
        int n_sent;
        logic [15:0] bl;
        errors = 0; beats_seen = 0;
        n_preempt = 0; n_complete = 0; n_reject = 0;
        idle_m = 1; hold_off = 0; quiet = 0;
        for (int i = 0; i < NSLOT; i++) occ[i] = 1'b0;
        now_units = '0; run_idx = 0; run_ok = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_beat(directed[i].act, directed[i].id, directed[i].bl);
        drain_results();

        // The long job still holds one slot: fill the rest, then one add more is rejected.
        for (int i = 0; i < NSLOT; i++) send_beat(ACT_ADD, 8'(100 + i), 16'(i + 1));
        drain_results();
        if (pending_results.size() == 0 && n_reject != 1) begin
            $error("reject count: expected 1, got %0d", n_reject);
            errors++;
        end

        // Random part: mostly ticks with short bursts, some long ones.
        n_sent = 0;
        while (n_sent < 1150) begin
            if (n_sent == 300) quiet = 1;
            if (n_sent == 450) quiet = 0;
            if (n_sent == 600) hold_off = 1;
            if (n_sent == 800) drain_results();
            if (n_sent == 900) idle_m = 0;
            if (n_sent == 1000) idle_m = 1;
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(9))
                    0:       bl = 16'($urandom_range(65535));
                    1:       bl = 16'd0;
                    default: bl = 16'($urandom_range(1, 12));
                endcase
                send_beat(ACT_ADD, 8'($urandom_range(255)), bl);
            end else begin
                send_beat(ACT_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
            end
            n_sent++;
        end
        drain_results();
        repeat (60) @(posedge aclk);

        $display("Run covered %0d result beats: %0d preempted, %0d completed, %0d rejected.",
                 beats_seen, n_preempt, n_complete, n_reject);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/srtf_pkg.sv
design/srtf_ram.sv
design/srtf_preemptive_scheduler_unit.sv
tb/sv/tb_srtf_preemptive_scheduler_unit.sv
